[rtl/vrf_pkg.sv]
// vrf_pkg: shared types, constants and the output finishing function
// for the vertical reduce filter. No dependencies.

package vrf_pkg;

  // line geometry and fixed-point format
  localparam int LINE_WIDTH    = 4096;
  localparam int COL_W         = $clog2(LINE_WIDTH);
  localparam int FRACTION_BITS = 12;
  localparam int SUM_W         = 32;
  localparam int PIX_W         = 8;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = PIX_W + 1 + COEF_W;

  localparam logic [SUM_W-1:0] ROUND_INIT = SUM_W'(1) << (FRACTION_BITS - 1);
  localparam logic [SUM_W-1:0] PIX_MAX    = SUM_W'((1 << PIX_W) - 1);

  // input transaction
  typedef struct packed {
    logic [PIX_W-1:0]         sample;
    logic signed [COEF_W-1:0] coefficient;
    logic [COL_W-1:0]         column;
    logic                     first_tap;
    logic                     last_tap;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [COL_W-1:0] column_out;
  } out_item_t;

  // accumulator memory write port
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [SUM_W-1:0] data;
  } ram_wr_t;

  // finished column sum handed to the output register
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] column;
    logic [SUM_W-1:0] sum;
  } done_t;

  // shift, then clamp to the pixel range; negative sums give zero
  function automatic logic [PIX_W-1:0] finish_pixel(input logic [SUM_W-1:0] acc);
    logic [SUM_W-1:0] v;
    logic [PIX_W-1:0] r;
    v = acc >> FRACTION_BITS;
    if (acc[SUM_W-1]) begin
      r = '0;
    end else if (v > PIX_MAX) begin
      r = PIX_MAX[PIX_W-1:0];
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/vertical_reduce_filter_u8_unit.sv]
// vertical_reduce_filter_u8_unit: top level of the vertical reduce filter.
// Depends on vrf_pkg, vrf_accum and vrf_sum_ram.
//
// Usage: each input transaction on item carries one pixel of one tap row at
// one column, the signed tap weight and first/last tap flags. The first tap
// of a column loads the rounding constant; every tap adds sample times
// coefficient into that column's 32-bit sum held in a 4096-entry memory.
// The last tap emits one result transaction with the shifted, clamped pixel
// and its column; other taps emit nothing.
// Path: a last tap is registered into the multiply stage, then its memory
// read-modify-write sum is registered into the output register.
// Throughput: one transaction per cycle when not stalled, set by the single
// read port and single write port of the sum memory; a column repeated on
// consecutive cycles is served by forwarding the previous write.
// Reset: clears the pipeline and output valid; the sum memory is not
// cleared, and each column must see its first tap before further taps.
// Stall: while a result waits and result_ready is low, the whole pipeline
// holds and item_ready is low; it restarts without loss when taken.

module vertical_reduce_filter_u8_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  vrf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output vrf_pkg::out_item_t result
);

  logic                      advance;
  logic [vrf_pkg::COL_W-1:0] rd_addr;
  logic [vrf_pkg::SUM_W-1:0] rd_data;
  vrf_pkg::ram_wr_t          wr;
  vrf_pkg::done_t            done;
  logic [vrf_pkg::COL_W-1:0] out_column;
  logic [vrf_pkg::SUM_W-1:0] out_sum;

  // pipeline moves whenever the output register is free or being emptied
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  vrf_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr),
    .done       (done)
  );

  vrf_sum_ram u_sum_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= done.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_column <= done.column;
      out_sum    <= done.sum;
    end
  end

  // shift and clamp
  assign result.pixel_out  = vrf_pkg::finish_pixel(out_sum);
  assign result.column_out = out_column;

endmodule

[rtl/vrf_sum_ram.sv]
// vrf_sum_ram: per-column accumulator memory, one write and one read port,
// registered read data. Depends on vrf_pkg.

module vrf_sum_ram (
  input  logic                           clk,
  input  vrf_pkg::ram_wr_t               wr,
  input  logic [vrf_pkg::COL_W-1:0]      rd_addr,
  output logic [vrf_pkg::SUM_W-1:0]      rd_data
);

  logic [vrf_pkg::SUM_W-1:0] mem [vrf_pkg::LINE_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/vrf_accum.sv]
// vrf_accum: multiply stage and read-modify-write of the column sums,
// with forwarding of the previous write. Depends on vrf_pkg.

module vrf_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      item_valid,
  input  vrf_pkg::in_item_t         item,
  output logic [vrf_pkg::COL_W-1:0] rd_addr,
  input  logic [vrf_pkg::SUM_W-1:0] rd_data,
  output vrf_pkg::ram_wr_t          wr,
  output vrf_pkg::done_t            done
);

  logic                               s1_valid;
  logic [vrf_pkg::COL_W-1:0]          s1_column;
  logic                               s1_first;
  logic                               s1_last;
  logic [vrf_pkg::SUM_W-1:0]          s1_product;
  logic signed [vrf_pkg::PROD_W-1:0]  product;
  logic                               fwd_hit;
  logic [vrf_pkg::SUM_W-1:0]          fwd_data;
  logic [vrf_pkg::SUM_W-1:0]          base;
  logic [vrf_pkg::SUM_W-1:0]          sum;

  // unsigned sample times signed weight
  assign product = $signed({1'b0, item.sample}) * item.coefficient;

  // re-read the held column while stalled so read data stays current
  assign rd_addr = advance ? item.column : s1_column;

  // stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_column  <= item.column;
      s1_first   <= item.first_tap;
      s1_last    <= item.last_tap;
      s1_product <= {{(vrf_pkg::SUM_W - vrf_pkg::PROD_W){product[vrf_pkg::PROD_W-1]}},
                     product};
    end
  end

  // forward a write that lands on the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wr.data;
  end

  // accumulate, wrapping modulo 2^32
  always_comb begin
    if (s1_first) begin
      base = vrf_pkg::ROUND_INIT;
    end else if (fwd_hit) begin
      base = fwd_data;
    end else begin
      base = rd_data;
    end
    sum = base + s1_product;
  end

  // write back and hand off
  assign wr.en       = s1_valid && advance;
  assign wr.addr     = s1_column;
  assign wr.data     = sum;
  assign done.valid  = s1_valid && s1_last;
  assign done.column = s1_column;
  assign done.sum    = sum;

endmodule
